[hw/rtl/bdpa_pkg.sv]
// Shared types and constants for the delta patch applier.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package bdpa_pkg;

    // Old image storage depth and its address width.
    localparam int OLD_DEPTH = 65536;
    localparam int OLD_AW    = $clog2(OLD_DEPTH);

    // Input item kinds.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CTRL  = 2'd1;
    localparam logic [1:0] ACT_DIFF  = 2'd2;
    localparam logic [1:0] ACT_EXTRA = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_OLD_SIZE = 1'b0;
    localparam logic REG_NEW_SIZE = 1'b1;

    // What the control stage hands to the output stage for one item.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data;
        logic [23:0] index;
        logic        last;
        logic        use_old;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/binary_delta_patch_applier.sv]
// Top level of the delta patch applier: input register, configuration registers,
// sequencer, old image memory and output stage. Depends on bdpa_pkg.
//
// The block takes one item per clock while the result side does not stall and
// returns one result per item. A beat is taken into the input register when it is
// accepted; the sequencer state, the old image read and the output stage's hold
// register are then loaded together, and the result register after that. The single
// read port of the old image memory is used once per item, which is what holds
// the rate at one item per cycle. Stall on the result side backs up through the
// stages, but empty stages still fill. Load old bytes before any diff bytes that
// read them; the memory is not cleared by reset, so diff bytes must only read
// positions that were loaded. Configuration (old_size at 0x0, new_size at 0x4)
// should be written with the block idle.
`default_nettype none

module binary_delta_patch_applier
    import bdpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_old_addr,
    input  wire logic [23:0] i_diff_len,
    input  wire logic [23:0] i_extra_len,
    input  wire logic signed [31:0] i_seek,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic [23:0]      o_out_index,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [16:0] r_old_size;
    logic [23:0] r_new_size;

    logic        r_s1_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_data_byte;
    logic [15:0] r_old_addr;
    logic [23:0] r_diff_len;
    logic [23:0] r_extra_len;
    logic [31:0] r_seek;

    logic              s1_ready;
    logic              s1_fire;
    logic              s2_ready;
    logic              accept;
    logic              cfg_write;
    logic              mem_we;
    logic [OLD_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [OLD_AW-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    t_res              res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_NEW_SIZE) ? {8'd0, r_new_size} : {15'd0, r_old_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_size <= '0;
            r_new_size <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_OLD_SIZE: r_old_size <= pwdata[16:0];
                REG_NEW_SIZE: r_new_size <= pwdata[23:0];
                default:      r_old_size <= r_old_size;
            endcase
        end
    end

    assign s1_ready = !r_s1_valid || s2_ready;
    assign s1_fire  = r_s1_valid && s2_ready;
    assign accept   = i_valid && s1_ready;
    assign o_stall  = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= i_action;
            r_data_byte <= i_data_byte;
            r_old_addr  <= i_old_addr;
            r_diff_len  <= i_diff_len;
            r_extra_len <= i_extra_len;
            r_seek      <= i_seek;
        end
    end

    bdpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_action    (r_action),
        .i_data_byte (r_data_byte),
        .i_old_addr  (r_old_addr),
        .i_diff_len  (r_diff_len),
        .i_extra_len (r_extra_len),
        .i_seek      (r_seek),
        .i_old_size  (r_old_size),
        .i_new_size  (r_new_size),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .o_res       (res)
    );

    bdpa_old_mem u_old_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (s1_fire),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bdpa_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s1_fire),
        .i_res       (res),
        .i_old_byte  (mem_rdata),
        .i_stall     (i_stall),
        .o_ready     (s2_ready),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_byte  (o_out_byte),
        .o_out_index (o_out_index),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

[hw/rtl/bdpa_old_mem.sv]
// Old image memory: one write port and one registered read port.
// Depends on bdpa_pkg for the depth and address width.
`default_nettype none

module bdpa_old_mem
    import bdpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [OLD_AW-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [OLD_AW-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] mem [OLD_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/bdpa_ctrl.sv]
// Patch sequencer: decodes one registered item, keeps positions and run counters,
// and issues the old image access. Depends on bdpa_pkg.
`default_nettype none

module bdpa_ctrl
    import bdpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [1:0]        i_action,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [15:0]       i_old_addr,
    input  wire logic [23:0]       i_diff_len,
    input  wire logic [23:0]       i_extra_len,
    input  wire logic [31:0]       i_seek,
    input  wire logic [16:0]       i_old_size,
    input  wire logic [23:0]       i_new_size,
    output logic                   o_mem_we,
    output logic [OLD_AW-1:0]      o_mem_waddr,
    output logic [7:0]             o_mem_wdata,
    output logic [OLD_AW-1:0]      o_mem_raddr,
    output t_res                   o_res
);

    logic [31:0] r_old_pos, n_old_pos;
    logic [23:0] r_new_pos, n_new_pos;
    logic [23:0] r_diff_left, n_diff_left;
    logic [23:0] r_extra_left, n_extra_left;
    logic [31:0] r_pend_seek, n_pend_seek;
    logic        r_error, n_error;

    logic        busy;
    logic [31:0] limit;
    logic [31:0] size_ext;
    logic [31:0] addr_ext;
    logic [25:0] end_all;
    logic        emit_last;
    logic [23:0] diff_dec;
    logic [23:0] extra_dec;
    logic        write_en;

    assign busy      = (r_diff_left != 24'd0) || (r_extra_left != 24'd0);
    assign size_ext  = {15'd0, i_old_size};
    assign limit     = (size_ext < 32'(OLD_DEPTH)) ? size_ext : 32'(OLD_DEPTH);
    assign addr_ext  = {16'd0, i_old_addr};
    assign end_all   = {2'b00, r_new_pos} + {2'b00, i_diff_len} + {2'b00, i_extra_len};
    assign emit_last = (({1'b0, r_new_pos} + 25'd1) == {1'b0, i_new_size});
    assign diff_dec  = r_diff_left - 24'd1;
    assign extra_dec = r_extra_left - 24'd1;

    always_comb begin
        n_old_pos    = r_old_pos;
        n_new_pos    = r_new_pos;
        n_diff_left  = r_diff_left;
        n_extra_left = r_extra_left;
        n_pend_seek  = r_pend_seek;
        n_error      = r_error;
        write_en     = 1'b0;
        o_res        = '0;
        o_res.status = ST_OK;

        if (r_error) begin
            o_res.status = ST_ERR;
        end else begin
            case (i_action)
                ACT_LOAD: begin
                    if (busy) begin
                        o_res.status = ST_ORDER;
                    end else begin
                        write_en = addr_ext < 32'(OLD_DEPTH);
                    end
                end
                ACT_CTRL: begin
                    if (busy || (r_new_pos >= i_new_size)) begin
                        o_res.status = ST_ORDER;
                    end else if (end_all > {2'b00, i_new_size}) begin
                        n_error      = 1'b1;
                        o_res.status = ST_ERR;
                    end else begin
                        n_diff_left  = i_diff_len;
                        n_extra_left = i_extra_len;
                        n_pend_seek  = i_seek;
                        // With both runs empty the seek lands right away.
                        if ((i_diff_len == 24'd0) && (i_extra_len == 24'd0)) begin
                            n_old_pos = r_old_pos + i_seek;
                        end
                    end
                end
                ACT_DIFF: begin
                    if (r_diff_left == 24'd0) begin
                        o_res.status = ST_ORDER;
                    end else begin
                        o_res.status  = ST_EMIT;
                        o_res.data    = i_data_byte;
                        o_res.index   = r_new_pos;
                        o_res.last    = emit_last;
                        o_res.use_old = r_old_pos < limit;
                        n_diff_left   = diff_dec;
                        n_new_pos     = r_new_pos + 24'd1;
                        if ((diff_dec == 24'd0) && (r_extra_left == 24'd0)) begin
                            n_old_pos = r_old_pos + 32'd1 + r_pend_seek;
                        end else begin
                            n_old_pos = r_old_pos + 32'd1;
                        end
                    end
                end
                default: begin
                    if ((r_diff_left != 24'd0) || (r_extra_left == 24'd0)) begin
                        o_res.status = ST_ORDER;
                    end else begin
                        o_res.status = ST_EMIT;
                        o_res.data   = i_data_byte;
                        o_res.index  = r_new_pos;
                        o_res.last   = emit_last;
                        n_extra_left = extra_dec;
                        n_new_pos    = r_new_pos + 24'd1;
                        if (extra_dec == 24'd0) begin
                            n_old_pos = r_old_pos + r_pend_seek;
                        end
                    end
                end
            endcase
        end
    end

    assign o_mem_we    = i_fire && write_en;
    assign o_mem_waddr = addr_ext[OLD_AW-1:0];
    assign o_mem_wdata = i_data_byte;
    assign o_mem_raddr = r_old_pos[OLD_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_pos    <= '0;
            r_new_pos    <= '0;
            r_diff_left  <= '0;
            r_extra_left <= '0;
            r_pend_seek  <= '0;
            r_error      <= 1'b0;
        end else if (i_fire) begin
            r_old_pos    <= n_old_pos;
            r_new_pos    <= n_new_pos;
            r_diff_left  <= n_diff_left;
            r_extra_left <= n_extra_left;
            r_pend_seek  <= n_pend_seek;
            r_error      <= n_error;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bdpa_emit.sv]
// Output side: holds a decided item while its old byte is read, adds it in,
// and presents the result register. Depends on bdpa_pkg.
`default_nettype none

module bdpa_emit
    import bdpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_res        i_res,
    input  wire logic [7:0]  i_old_byte,
    input  wire logic        i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_byte,
    output logic [23:0]      o_out_index,
    output logic             o_last
);

    logic        r_s2_valid;
    t_res        r_s2;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_byte;
    logic [23:0] r_index;
    logic        r_last;

    logic        out_ready;
    logic        s2_move;
    logic [7:0]  n_byte;

    assign out_ready = !r_out_valid || !i_stall;
    assign s2_move   = r_s2_valid && out_ready;
    assign o_ready   = !r_s2_valid || out_ready;

    // Diff bytes within the old size add the old byte modulo 256; everything else passes as is.
    assign n_byte = r_s2.use_old ? (r_s2.data + i_old_byte) : r_s2.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2 <= i_res;
        end
        if (s2_move) begin
            r_status <= r_s2.status;
            r_byte   <= n_byte;
            r_index  <= r_s2.index;
            r_last   <= r_s2.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_out_byte  = r_byte;
    assign o_out_index = r_index;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[hw/rtl/bdpa_checker.sv]
// Port-level checks for the delta patch applier, bound to the top level.
// Depends on bdpa_pkg for the status codes.
`default_nettype none

module bdpa_checker
    import bdpa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_out_byte,
    input wire logic [23:0] o_out_index,
    input wire logic        o_last
);

    // A held result beat keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_byte)
            && $stable(o_out_index) && $stable(o_last))
        else $error("result beat changed while stalled");

    // Only emitted bytes carry a byte, an index or a last mark.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_EMIT) |->
            (o_out_byte == 8'd0) && (o_out_index == 24'd0) && !o_last)
        else $error("non-byte result carries payload");

    // A patch error sticks: a result beat that directly follows an error beat is an error too.
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_status == ST_ERR) ##1 o_valid |-> o_status == ST_ERR)
        else $error("patch error did not stick");

    // Consecutive emitted bytes have consecutive indexes.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_status == ST_EMIT) && !o_last ##1
            o_valid && (o_status == ST_EMIT) |->
            o_out_index == $past(o_out_index) + 24'd1)
        else $error("emitted byte index skipped");

endmodule

bind binary_delta_patch_applier bdpa_checker u_bdpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_out_byte  (o_out_byte),
    .o_out_index (o_out_index),
    .o_last      (o_last)
);

`default_nettype wire
